FILE: rtl/mtep_pkg.sv
`timescale 1ns / 1ps

package mtep_pkg;

   // Parse phases
   localparam logic [3:0] PH_DELTA     = 4'd0;
   localparam logic [3:0] PH_STATUS    = 4'd1;
   localparam logic [3:0] PH_CHAN      = 4'd2;
   localparam logic [3:0] PH_META_TYPE = 4'd3;
   localparam logic [3:0] PH_SYX_LEN   = 4'd4;
   localparam logic [3:0] PH_META_LEN  = 4'd5;
   localparam logic [3:0] PH_SYX_BODY  = 4'd6;
   localparam logic [3:0] PH_META_BODY = 4'd7;
   localparam logic [3:0] PH_HALT      = 4'd8;

   // Completed event kinds
   localparam logic [1:0] KIND_CHANNEL = 2'd0;
   localparam logic [1:0] KIND_SYSEX   = 2'd1;
   localparam logic [1:0] KIND_META    = 2'd2;

   // Status bytes and meta types
   localparam logic [7:0] STATUS_META   = 8'hFF;
   localparam logic [7:0] STATUS_SYSEX  = 8'hF0;
   localparam logic [7:0] STATUS_ESCAPE = 8'hF7;
   localparam logic [3:0] UPPER_SYSTEM  = 4'hF;
   localparam logic [3:0] UPPER_PROGRAM = 4'hC;
   localparam logic [3:0] UPPER_CHAN_PRESSURE = 4'hD;
   localparam logic [7:0] META_TEMPO    = 8'h51;
   localparam logic [7:0] META_TIME_SIG = 8'h58;
   localparam logic [7:0] META_KEY_SIG  = 8'h59;

   localparam int unsigned LEN_W = 28;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic        event_end;
      logic [1:0]  event_kind;
      logic [3:0]  channel;
      logic [23:0] tempo_us;
      logic        tempo_valid;
      logic [31:0] time_signature;
      logic        time_signature_valid;
      logic [15:0] key_signature;
      logic        key_signature_valid;
      logic        parse_error;
   } rsp_type;

   typedef struct packed {
      logic [3:0]       parse_phase;
      logic [LEN_W-1:0] length_accumulator;
      logic [2:0]       length_byte_count;
      logic [7:0]       chan_status;
      logic [7:0]       meta_type;
      logic [LEN_W-1:0] bytes_remaining;
      logic [31:0]      meta_capture;
      logic [2:0]       capture_index;
      logic [23:0]      tempo_store;
      logic             tempo_seen;
      logic [31:0]      time_sig_store;
      logic             time_sig_seen;
      logic [15:0]      key_sig_store;
      logic             key_sig_seen;
      logic             error_seen;
   } state_type;

   localparam state_type STATE_RESET = '{parse_phase: PH_DELTA, default: '0};

endpackage

FILE: rtl/mtep_req_if.sv
`timescale 1ns / 1ps

interface mtep_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_byte;
   logic       last_byte;

   modport source (output valid, data_byte, first_byte, last_byte, input ready);
   modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

FILE: rtl/mtep_rsp_if.sv
`timescale 1ns / 1ps

interface mtep_rsp_if;
   logic        valid;
   logic        ready;
   logic        event_end;
   logic [1:0]  event_kind;
   logic [3:0]  channel;
   logic [23:0] tempo_us;
   logic        tempo_valid;
   logic [31:0] time_signature;
   logic        time_signature_valid;
   logic [15:0] key_signature;
   logic        key_signature_valid;
   logic        parse_error;

   modport source (output valid, event_end, event_kind, channel, tempo_us, tempo_valid,
                   time_signature, time_signature_valid, key_signature,
                   key_signature_valid, parse_error, input ready);
   modport sink   (input valid, event_end, event_kind, channel, tempo_us, tempo_valid,
                   time_signature, time_signature_valid, key_signature,
                   key_signature_valid, parse_error, output ready);
endinterface

FILE: rtl/mtep_step.sv
`timescale 1ns / 1ps

// One byte of parsing: next parse state and the response for this byte
module mtep_step (
   input  mtep_pkg::state_type st,
   input  mtep_pkg::req_type   req,
   output mtep_pkg::state_type st_next,
   output mtep_pkg::rsp_type   rsp
);

   // data bytes that follow a channel status
   function automatic logic [1:0] data_count(input logic [7:0] status);
      if (status[7:4] == mtep_pkg::UPPER_PROGRAM ||
          status[7:4] == mtep_pkg::UPPER_CHAN_PRESSURE)
         return 2'd1;
      return 2'd2;
   endfunction

   // commit captured meta payload to the matching store
   function automatic mtep_pkg::state_type finish_meta(input mtep_pkg::state_type f);
      logic [31:0] aligned;
      mtep_pkg::state_type r;
      r = f;
      unique case (f.capture_index)
         3'd1:    aligned = {f.meta_capture[7:0], 24'd0};
         3'd2:    aligned = {f.meta_capture[15:0], 16'd0};
         3'd3:    aligned = {f.meta_capture[23:0], 8'd0};
         default: aligned = f.meta_capture;
      endcase
      if (f.capture_index != 3'd0 && f.capture_index <= 3'd4) begin
         if (f.meta_type == mtep_pkg::META_TEMPO && f.capture_index >= 3'd3) begin
            r.tempo_store = aligned[31:8];
            r.tempo_seen  = 1'b1;
         end else if (f.meta_type == mtep_pkg::META_TIME_SIG &&
                      f.capture_index >= 3'd4) begin
            r.time_sig_store = aligned;
            r.time_sig_seen  = 1'b1;
         end else if (f.meta_type == mtep_pkg::META_KEY_SIG &&
                      f.capture_index >= 3'd2) begin
            r.key_sig_store = aligned[31:16];
            r.key_sig_seen  = 1'b1;
         end
      end
      return r;
   endfunction

   mtep_pkg::state_type s;
   logic                evt_end;
   logic [1:0]          kind;
   logic [3:0]          chan;
   logic [27:0]         vlq_acc;
   logic [2:0]          vlq_cnt;
   logic                vlq_more;
   logic                vlq_long;
   logic [27:0]         br_dec;
   logic [1:0]          rs_count;

   always_comb begin
      s        = req.first_byte ? mtep_pkg::STATE_RESET : st;
      evt_end  = 1'b0;
      kind     = mtep_pkg::KIND_CHANNEL;
      chan     = 4'd0;
      vlq_acc  = {s.length_accumulator[20:0], req.data_byte[6:0]};
      vlq_cnt  = s.length_byte_count + 3'd1;
      vlq_more = req.data_byte[7];
      vlq_long = req.data_byte[7] && (vlq_cnt >= 3'd4);
      br_dec   = s.bytes_remaining - 28'd1;
      rs_count = data_count(s.chan_status);

      unique case (s.parse_phase)
         mtep_pkg::PH_DELTA: begin
            s.length_accumulator = vlq_acc;
            s.length_byte_count  = vlq_cnt;
            if (vlq_long) begin
               s.error_seen  = 1'b1;
               s.parse_phase = mtep_pkg::PH_HALT;
            end else if (!vlq_more) begin
               s.length_accumulator = '0;
               s.length_byte_count  = '0;
               s.parse_phase        = mtep_pkg::PH_STATUS;
            end
         end
         mtep_pkg::PH_STATUS: begin
            if (req.data_byte == mtep_pkg::STATUS_META) begin
               s.chan_status = '0;
               s.parse_phase = mtep_pkg::PH_META_TYPE;
            end else if (req.data_byte == mtep_pkg::STATUS_SYSEX ||
                         req.data_byte == mtep_pkg::STATUS_ESCAPE) begin
               s.chan_status        = '0;
               s.length_accumulator = '0;
               s.length_byte_count  = '0;
               s.parse_phase        = mtep_pkg::PH_SYX_LEN;
            end else if (req.data_byte[7:4] == mtep_pkg::UPPER_SYSTEM) begin
               s.error_seen  = 1'b1;
               s.parse_phase = mtep_pkg::PH_HALT;
            end else if (req.data_byte[7]) begin
               s.chan_status     = req.data_byte;
               s.bytes_remaining = {26'd0, data_count(req.data_byte)};
               s.parse_phase     = mtep_pkg::PH_CHAN;
            end else if (s.chan_status != 8'd0) begin
               // running status: this byte is the first data byte
               if (rs_count == 2'd1) begin
                  s.bytes_remaining = '0;
                  evt_end           = 1'b1;
                  chan              = s.chan_status[3:0];
                  s.parse_phase     = mtep_pkg::PH_DELTA;
               end else begin
                  s.bytes_remaining = 28'd1;
                  s.parse_phase     = mtep_pkg::PH_CHAN;
               end
            end else begin
               s.error_seen  = 1'b1;
               s.parse_phase = mtep_pkg::PH_HALT;
            end
         end
         mtep_pkg::PH_CHAN: begin
            s.bytes_remaining = br_dec;
            if (br_dec == 28'd0) begin
               evt_end       = 1'b1;
               chan          = s.chan_status[3:0];
               s.parse_phase = mtep_pkg::PH_DELTA;
            end
         end
         mtep_pkg::PH_META_TYPE: begin
            s.meta_type          = req.data_byte;
            s.length_accumulator = '0;
            s.length_byte_count  = '0;
            s.meta_capture       = '0;
            s.capture_index      = '0;
            s.parse_phase        = mtep_pkg::PH_META_LEN;
         end
         mtep_pkg::PH_SYX_LEN, mtep_pkg::PH_META_LEN: begin
            s.length_accumulator = vlq_acc;
            s.length_byte_count  = vlq_cnt;
            if (vlq_long) begin
               s.error_seen  = 1'b1;
               s.parse_phase = mtep_pkg::PH_HALT;
            end else if (!vlq_more) begin
               s.bytes_remaining    = vlq_acc;
               s.length_accumulator = '0;
               s.length_byte_count  = '0;
               if (vlq_acc == 28'd0) begin
                  evt_end = 1'b1;
                  if (s.parse_phase == mtep_pkg::PH_META_LEN) begin
                     kind = mtep_pkg::KIND_META;
                     s    = finish_meta(s);
                  end else begin
                     kind = mtep_pkg::KIND_SYSEX;
                  end
                  s.parse_phase = mtep_pkg::PH_DELTA;
               end else if (s.parse_phase == mtep_pkg::PH_META_LEN) begin
                  s.parse_phase = mtep_pkg::PH_META_BODY;
               end else begin
                  s.parse_phase = mtep_pkg::PH_SYX_BODY;
               end
            end
         end
         mtep_pkg::PH_SYX_BODY, mtep_pkg::PH_META_BODY: begin
            // keep the first four meta payload bytes
            if (s.parse_phase == mtep_pkg::PH_META_BODY && s.capture_index < 3'd4) begin
               s.meta_capture  = {s.meta_capture[23:0], req.data_byte};
               s.capture_index = s.capture_index + 3'd1;
            end
            s.bytes_remaining = br_dec;
            if (br_dec == 28'd0) begin
               evt_end = 1'b1;
               if (s.parse_phase == mtep_pkg::PH_META_BODY) begin
                  kind = mtep_pkg::KIND_META;
                  s    = finish_meta(s);
               end else begin
                  kind = mtep_pkg::KIND_SYSEX;
               end
               s.parse_phase = mtep_pkg::PH_DELTA;
            end
         end
         default: begin
            s.parse_phase = mtep_pkg::PH_HALT;
         end
      endcase

      // end of track: must land between events
      if (req.last_byte && s.parse_phase != mtep_pkg::PH_HALT) begin
         if (s.parse_phase != mtep_pkg::PH_DELTA || s.length_byte_count != 3'd0) begin
            s.error_seen  = 1'b1;
            s.parse_phase = mtep_pkg::PH_HALT;
         end else begin
            s.chan_status        = '0;
            s.length_accumulator = '0;
            s.length_byte_count  = '0;
            s.bytes_remaining    = '0;
         end
      end

      st_next                  = s;
      rsp.event_end            = evt_end;
      rsp.event_kind           = kind;
      rsp.channel              = chan;
      rsp.tempo_us             = s.tempo_store;
      rsp.tempo_valid          = s.tempo_seen;
      rsp.time_signature       = s.time_sig_store;
      rsp.time_signature_valid = s.time_sig_seen;
      rsp.key_signature        = s.key_sig_store;
      rsp.key_signature_valid  = s.key_sig_seen;
      rsp.parse_error          = s.error_seen;
   end

endmodule

FILE: rtl/midi_track_event_parser_top.sv
`timescale 1ns / 1ps

// Track-body parser for standard MIDI files, one byte per request.
// req_chan carries data_byte with first_byte (start of a track, clears all
// parse state, stores and error) and last_byte (end of track; an event or
// delta time cut short sets parse_error). Every request yields exactly one
// response on rsp_chan: an end-of-event pulse with kind and channel, the
// latest tempo, time signature and key signature with valid flags, and
// the sticky parse_error. After an error all bytes are ignored until the
// next first_byte.
// A request goes through the input register, then the response register,
// before it is shown on rsp_chan.
// Throughput: one byte per cycle while the receiver keeps up; the per-byte
// parse update is one logic pass between input and response register.
// Reset (synchronous) empties both registers and returns the parser to the
// delta-time phase with all stores cleared.
// When the receiver stalls, the response holds, the input register fills,
// and req_chan.ready drops only once both are occupied.
module midi_track_event_parser_top (
   input  logic              clock,
   input  logic              reset,
   mtep_req_if.sink          req_chan,
   mtep_rsp_if.source        rsp_chan
);

   mtep_pkg::req_type   s1_ff;
   mtep_pkg::req_type   s1_in;
   logic                s1_valid_ff;
   logic                s1_valid_in;
   mtep_pkg::rsp_type   rsp_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   mtep_pkg::state_type st_ff;
   mtep_pkg::state_type st_in;
   mtep_pkg::state_type step_state;
   mtep_pkg::rsp_type   step_rsp;
   logic                out_free;
   logic                s1_adv;
   logic                req_ready;

   mtep_step u_step (
      .st      (st_ff),
      .req     (s1_ff),
      .st_next (step_state),
      .rsp     (step_rsp)
   );

   // handshake and advance control
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_chan.ready;
      s1_adv       = s1_valid_ff && out_free;
      req_ready    = !s1_valid_ff || s1_adv;
      s1_valid_in  = req_ready ? req_chan.valid : s1_valid_ff;
      rsp_valid_in = s1_adv ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
      st_in        = s1_adv ? step_state : st_ff;
      s1_in.data_byte  = req_chan.data_byte;
      s1_in.first_byte = req_chan.first_byte;
      s1_in.last_byte  = req_chan.last_byte;
   end

   // control and parse state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         st_ff        <= mtep_pkg::STATE_RESET;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         st_ff        <= st_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_ready && req_chan.valid) begin
         s1_ff <= s1_in;
      end
      if (s1_adv) begin
         rsp_ff <= step_rsp;
      end
   end

   assign req_chan.ready                = req_ready;
   assign rsp_chan.valid                = rsp_valid_ff;
   assign rsp_chan.event_end            = rsp_ff.event_end;
   assign rsp_chan.event_kind           = rsp_ff.event_kind;
   assign rsp_chan.channel              = rsp_ff.channel;
   assign rsp_chan.tempo_us             = rsp_ff.tempo_us;
   assign rsp_chan.tempo_valid          = rsp_ff.tempo_valid;
   assign rsp_chan.time_signature       = rsp_ff.time_signature;
   assign rsp_chan.time_signature_valid = rsp_ff.time_signature_valid;
   assign rsp_chan.key_signature        = rsp_ff.key_signature;
   assign rsp_chan.key_signature_valid  = rsp_ff.key_signature_valid;
   assign rsp_chan.parse_error          = rsp_ff.parse_error;

   // error is sticky until a new track starts
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      st_ff.error_seen && !(s1_adv && s1_ff.first_byte) |=> st_ff.error_seen)
      else $error("parse error cleared without a new track");

   // halt phase and error flag go together
   a_halt_error: assert property (@(posedge clock) disable iff (reset)
      st_ff.error_seen == (st_ff.parse_phase == mtep_pkg::PH_HALT))
      else $error("halt phase and error flag disagree");

   // kind and channel stay zero unless an event ends
   a_idle_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.event_end |->
         rsp_ff.event_kind == mtep_pkg::KIND_CHANNEL && rsp_ff.channel == 4'd0)
      else $error("event fields set without event end");

   // a store without its valid flag stays cleared
   a_tempo_clear: assert property (@(posedge clock) disable iff (reset)
      !st_ff.tempo_seen |-> st_ff.tempo_store == 24'd0)
      else $error("tempo store written without valid flag");

   // a response is produced only from an occupied input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |=> !rsp_valid_ff || $stable(rsp_ff))
      else $error("response changed without a request in flight");

endmodule

FILE: bench/mtep_event_checker.sv
`timescale 1ns / 1ps

// Passive scoreboard for the track parser: mirrors the parse state per
// accepted request, queues the expected response and compares each
// accepted response with the oldest expectation.
module mtep_event_checker (
   input  logic clock,
   input  logic reset,
   mtep_req_if  req_mon,
   mtep_rsp_if  rsp_mon,
   output int   fail_count,
   output int   outstanding,
   output int   checked_count,
   output int   event_count,
   output int   halt_count
);
   import mtep_pkg::*;

   // Outcomes of taking one byte of a variable-length quantity
   localparam logic [1:0] VLQ_MORE = 2'd0;
   localparam logic [1:0] VLQ_DONE = 2'd1;
   localparam logic [1:0] VLQ_LONG = 2'd2;

   // Mirrored parse state
   logic [3:0]  phase;
   logic [27:0] len_acc;
   logic [2:0]  len_cnt;
   logic [7:0]  run_status;
   logic [7:0]  meta_code;
   logic [27:0] remaining;
   logic [31:0] capture;
   logic [2:0]  cap_count;
   logic [23:0] tempo;
   logic        tempo_ok;
   logic [31:0] timesig;
   logic        timesig_ok;
   logic [15:0] keysig;
   logic        keysig_ok;
   logic        err;

   rsp_type expected_q[$];
   int      mismatches = 0;
   int      responses = 0;
   int      events = 0;
   int      halts = 0;

   function automatic void clear_parser();
      phase      = PH_DELTA;
      len_acc    = '0;
      len_cnt    = '0;
      run_status = '0;
      meta_code  = '0;
      remaining  = '0;
      capture    = '0;
      cap_count  = '0;
      tempo      = '0;
      tempo_ok   = 1'b0;
      timesig    = '0;
      timesig_ok = 1'b0;
      keysig     = '0;
      keysig_ok  = 1'b0;
      err        = 1'b0;
   endfunction

   function automatic void enter_halt();
      err   = 1'b1;
      phase = PH_HALT;
      halts++;
   endfunction

   // Shift one length byte in; a continuation on the fourth byte is too long
   function automatic logic [1:0] take_length_byte(logic [7:0] b);
      len_acc = {len_acc[20:0], b[6:0]};
      len_cnt = len_cnt + 3'd1;
      if (b[7])
         return (len_cnt >= 3'd4) ? VLQ_LONG : VLQ_MORE;
      return VLQ_DONE;
   endfunction

   function automatic logic [27:0] data_bytes_for(logic [7:0] status);
      if (status[7:4] == UPPER_PROGRAM || status[7:4] == UPPER_CHAN_PRESSURE)
         return 28'd1;
      return 28'd2;
   endfunction

   // Update the tempo / time / key stores from a finished meta payload
   function automatic void latch_meta();
      logic [31:0] aligned;
      if (cap_count == 3'd0 || cap_count > 3'd4)
         return;
      aligned = capture << (8 * (4 - int'(cap_count)));
      if (meta_code == META_TEMPO && cap_count >= 3'd3) begin
         tempo    = aligned[31:8];
         tempo_ok = 1'b1;
      end else if (meta_code == META_TIME_SIG && cap_count >= 3'd4) begin
         timesig    = aligned;
         timesig_ok = 1'b1;
      end else if (meta_code == META_KEY_SIG && cap_count >= 3'd2) begin
         keysig    = aligned[31:16];
         keysig_ok = 1'b1;
      end
   endfunction

   // One byte through the parser; returns the response it should produce
   function automatic rsp_type parse_byte(logic [7:0] b, logic first_flag, logic last_flag);
      rsp_type    r;
      logic [1:0] vlq;
      logic       is_meta;
      r = '0;
      if (first_flag)
         clear_parser();
      case (phase)
         PH_DELTA: begin
            vlq = take_length_byte(b);
            if (vlq == VLQ_LONG) begin
               enter_halt();
            end else if (vlq == VLQ_DONE) begin
               len_acc = '0;
               len_cnt = '0;
               phase   = PH_STATUS;
            end
         end
         PH_STATUS: begin
            if (b == STATUS_META) begin
               run_status = '0;
               phase      = PH_META_TYPE;
            end else if (b == STATUS_SYSEX || b == STATUS_ESCAPE) begin
               run_status = '0;
               len_acc    = '0;
               len_cnt    = '0;
               phase      = PH_SYX_LEN;
            end else if (b[7:4] == UPPER_SYSTEM) begin
               enter_halt();
            end else if (b[7]) begin
               run_status = b;
               remaining  = data_bytes_for(b);
               phase      = PH_CHAN;
            end else if (run_status != 8'd0) begin
               // running status: this byte is already the first data byte
               remaining = data_bytes_for(run_status) - 28'd1;
               if (remaining == 28'd0) begin
                  r.event_end  = 1'b1;
                  r.event_kind = KIND_CHANNEL;
                  r.channel    = run_status[3:0];
                  phase        = PH_DELTA;
               end else begin
                  phase = PH_CHAN;
               end
            end else begin
               enter_halt();
            end
         end
         PH_CHAN: begin
            remaining = remaining - 28'd1;
            if (remaining == 28'd0) begin
               r.event_end  = 1'b1;
               r.event_kind = KIND_CHANNEL;
               r.channel    = run_status[3:0];
               phase        = PH_DELTA;
            end
         end
         PH_META_TYPE: begin
            meta_code = b;
            len_acc   = '0;
            len_cnt   = '0;
            capture   = '0;
            cap_count = '0;
            phase     = PH_META_LEN;
         end
         PH_SYX_LEN, PH_META_LEN: begin
            vlq = take_length_byte(b);
            if (vlq == VLQ_LONG) begin
               enter_halt();
            end else if (vlq == VLQ_DONE) begin
               is_meta   = (phase == PH_META_LEN);
               remaining = len_acc;
               len_acc   = '0;
               len_cnt   = '0;
               if (remaining == 28'd0) begin
                  r.event_end  = 1'b1;
                  r.event_kind = is_meta ? KIND_META : KIND_SYSEX;
                  if (is_meta)
                     latch_meta();
                  phase = PH_DELTA;
               end else begin
                  phase = is_meta ? PH_META_BODY : PH_SYX_BODY;
               end
            end
         end
         PH_SYX_BODY, PH_META_BODY: begin
            is_meta = (phase == PH_META_BODY);
            if (is_meta && cap_count < 3'd4) begin
               capture   = {capture[23:0], b};
               cap_count = cap_count + 3'd1;
            end
            remaining = remaining - 28'd1;
            if (remaining == 28'd0) begin
               r.event_end  = 1'b1;
               r.event_kind = is_meta ? KIND_META : KIND_SYSEX;
               if (is_meta)
                  latch_meta();
               phase = PH_DELTA;
            end
         end
         default: phase = PH_HALT;
      endcase

      // end of track: clean only between events
      if (last_flag && phase != PH_HALT) begin
         if (phase != PH_DELTA || len_cnt != 3'd0) begin
            enter_halt();
         end else begin
            run_status = '0;
            len_acc    = '0;
            len_cnt    = '0;
            remaining  = '0;
         end
      end

      r.tempo_us             = tempo;
      r.tempo_valid          = tempo_ok;
      r.time_signature       = timesig;
      r.time_signature_valid = timesig_ok;
      r.key_signature        = keysig;
      r.key_signature_valid  = keysig_ok;
      r.parse_error          = err;
      return r;
   endfunction

   function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Predict on accepted requests, compare on accepted responses
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_parser();
         expected_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready) begin
            want = parse_byte(req_mon.data_byte, req_mon.first_byte, req_mon.last_byte);
            if (want.event_end)
               events++;
            expected_q.push_back(want);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: response with no request pending, expected none, actual %0h",
                        $time, {rsp_mon.event_end, rsp_mon.event_kind, rsp_mon.channel});
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               compare_field("event_end", 32'(want.event_end), 32'(rsp_mon.event_end));
               compare_field("event_kind", 32'(want.event_kind), 32'(rsp_mon.event_kind));
               compare_field("channel", 32'(want.channel), 32'(rsp_mon.channel));
               compare_field("tempo_us", 32'(want.tempo_us), 32'(rsp_mon.tempo_us));
               compare_field("tempo_valid", 32'(want.tempo_valid),
                             32'(rsp_mon.tempo_valid));
               compare_field("time_signature", want.time_signature,
                             rsp_mon.time_signature);
               compare_field("time_signature_valid", 32'(want.time_signature_valid),
                             32'(rsp_mon.time_signature_valid));
               compare_field("key_signature", 32'(want.key_signature),
                             32'(rsp_mon.key_signature));
               compare_field("key_signature_valid", 32'(want.key_signature_valid),
                             32'(rsp_mon.key_signature_valid));
               compare_field("parse_error", 32'(want.parse_error),
                             32'(rsp_mon.parse_error));
               responses++;
            end
         end
      end
      fail_count    <= mismatches;
      outstanding   <= expected_q.size();
      checked_count <= responses;
      event_count   <= events;
      halt_count    <= halts;
   end

endmodule

FILE: bench/midi_track_event_parser_top_tb.sv
`timescale 1ns / 1ps

module midi_track_event_parser_top_tb;
   import mtep_pkg::*;

   localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
   localparam int         BYTES_PER_PHASE   = 400;

   logic clock;
   logic reset;

   mtep_req_if req_chan();
   mtep_rsp_if rsp_chan();

   int fail_count;
   int outstanding;
   int checked_count;
   int event_count;
   int halt_count;

   int idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int track_count = 0;

   logic [7:0] track_bytes[$];
   logic [7:0] gen_status;

   midi_track_event_parser_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   mtep_event_checker event_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (fail_count),
      .outstanding   (outstanding),
      .checked_count (checked_count),
      .event_count   (event_count),
      .halt_count    (halt_count)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Response side: random back-pressure at the current stall rate
   initial begin
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("midi_track_event_parser_top regression: fail");
      $finish;
   end

   // One request, with random idle cycles ahead of it
   task automatic send_byte(logic [7:0] b, logic first_flag, logic last_flag);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= b;
      req_chan.first_byte <= first_flag;
      req_chan.last_byte  <= last_flag;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sent_count++;
   endtask

   task automatic send_track(logic with_first, logic with_last);
      for (int i = 0; i < track_bytes.size(); i++)
         send_byte(track_bytes[i], with_first && i == 0,
                   with_last && i == track_bytes.size() - 1);
      track_count++;
   endtask

   // Variable-length quantity, padded with leading zero groups up to min_groups
   function automatic void push_length(int unsigned value, int min_groups);
      int groups;
      groups = 1;
      while (groups < 4 && (value >> (7 * groups)) != 0)
         groups++;
      if (groups < min_groups)
         groups = min_groups;
      for (int g = groups - 1; g >= 0; g--)
         track_bytes.push_back({g != 0, 7'(value >> (7 * g))});
   endfunction

   function automatic void push_delta();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         push_length($urandom_range(0, 127), 1);
      else if (pick < 85)
         push_length($urandom_range(0, 16383), $urandom_range(1, 3));
      else
         push_length($urandom & 32'h0FFF_FFFF, $urandom_range(1, 4));
   endfunction

   function automatic void push_body(int count);
      repeat (count)
         track_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // One event, mostly well-formed: channel message, sysex or meta
   function automatic void push_event();
      int         pick;
      int         len;
      logic [7:0] status;
      logic [7:0] code;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if (gen_status != 8'd0 && $urandom_range(0, 2) == 0) begin
            status = gen_status;
         end else begin
            status = {4'($urandom_range(8, 14)), 4'($urandom_range(0, 15))};
            track_bytes.push_back(status);
            gen_status = status;
         end
         len = (status[7:4] == UPPER_PROGRAM || status[7:4] == UPPER_CHAN_PRESSURE) ? 1 : 2;
         // mostly proper data bytes, a few with the top bit set
         repeat (len)
            track_bytes.push_back(8'(($urandom_range(0, 9) == 0) ? $urandom_range(0, 255)
                                                                 : $urandom_range(0, 127)));
      end else if (pick < 70) begin
         track_bytes.push_back($urandom_range(0, 1) ? STATUS_SYSEX : STATUS_ESCAPE);
         len = $urandom_range(0, 5);
         push_length(len, $urandom_range(1, 3));
         push_body(len);
         gen_status = 8'd0;
      end else begin
         case ($urandom_range(0, 4))
            0: code = META_TEMPO;
            1: code = META_TIME_SIG;
            2: code = META_KEY_SIG;
            3: code = META_END_OF_TRACK;
            default: code = 8'($urandom_range(0, 255));
         endcase
         case (code)
            META_TEMPO:    len = 3;
            META_TIME_SIG: len = 4;
            META_KEY_SIG:  len = 2;
            default:       len = 0;
         endcase
         // sometimes short or long payloads
         if ($urandom_range(0, 9) < 3)
            len = $urandom_range(0, 6);
         track_bytes.push_back(STATUS_META);
         track_bytes.push_back(code);
         push_length(len, $urandom_range(1, 2));
         push_body(len);
         gen_status = 8'd0;
      end
   endfunction

   // A track of random events, now and then broken or pure noise
   function automatic void build_track();
      int pick;
      track_bytes.delete();
      gen_status = 8'd0;
      if ($urandom_range(0, 19) == 0) begin
         push_body($urandom_range(1, 12));
         return;
      end
      repeat ($urandom_range(1, 8)) begin
         push_delta();
         push_event();
      end
      if ($urandom_range(0, 99) < 15) begin
         pick = $urandom_range(0, 4);
         case (pick)
            0: track_bytes.insert($urandom_range(0, track_bytes.size() - 1),
                                  8'($urandom_range(0, 255)));
            1: repeat ($urandom_range(1, 4))
                  if (track_bytes.size() > 1)
                     void'(track_bytes.pop_back());
            2: repeat (4)
                  track_bytes.push_front(8'h80 | 8'($urandom_range(0, 127)));
            3: begin
               // meta with a length that never terminates in four bytes
               track_bytes.push_back(8'h00);
               track_bytes.push_back(STATUS_META);
               track_bytes.push_back(8'($urandom_range(0, 255)));
               repeat (4)
                  track_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            end
            default: begin
               // data byte where a status is due, with no running status
               track_bytes.push_front(8'($urandom_range(0, 127)));
               track_bytes.push_front(8'h00);
            end
         endcase
      end
   endfunction

   initial begin
      int idle_plan[4];
      int stall_plan[4];
      int target;
      idle_plan  = '{0, 53, 0, 15};
      stall_plan = '{0, 0, 53, 15};

      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= 8'h00;
      req_chan.first_byte <= 1'b0;
      req_chan.last_byte  <= 1'b0;
      reset               <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: two-byte delta, poly pressure with a high data byte,
      // running status, program change, full-scale tempo, short key signature
      track_bytes = '{8'h81, 8'h00,
                      8'hAF, 8'h7F, 8'h80,
                      8'h00, 8'h00, 8'hFF,
                      8'h00, 8'hC0, 8'h05,
                      8'h00, STATUS_META, META_TEMPO, 8'h03, 8'hFF, 8'hFF, 8'hFF,
                      8'h00, STATUS_META, META_KEY_SIG, 8'h01, 8'h05};
      send_track(1'b1, 1'b1);
      // over-long delta halts; the trailing byte is ignored
      track_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_track(1'b1, 1'b1);

      // Random tracks through the idle and stall phases
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         target    = sent_count + BYTES_PER_PHASE;
         while (sent_count < target) begin
            build_track();
            send_track($urandom_range(0, 9) != 0, $urandom_range(0, 6) != 0);
         end
      end
      req_chan.valid <= 1'b0;

      // Drain
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d bytes in %0d tracks; %0d responses checked.",
               sent_count, track_count, checked_count);
      $display("Completed events: %0d; parser halts on error: %0d.", event_count, halt_count);
      if (fail_count == 0 && outstanding == 0) begin
         $display("midi_track_event_parser_top regression: pass");
      end else begin
         $display("midi_track_event_parser_top regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/mtep_pkg.sv
rtl/mtep_req_if.sv
rtl/mtep_rsp_if.sv
rtl/mtep_step.sv
rtl/midi_track_event_parser_top.sv
bench/mtep_event_checker.sv
bench/midi_track_event_parser_top_tb.sv
